// ===== sv/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the flow counter table.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int unsigned TableEntriesDef = 1024;

  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [15:0] DnsPort   = 16'd53;

  typedef enum logic [1:0] {
    StatOk     = 2'd0,
    StatFull   = 2'd1,
    StatAbsent = 2'd2
  } status_e;

  // first member lands in the top bits, so syn_count sits at bit 0
  typedef struct packed {
    logic [31:0] byte_count;
    logic [31:0] packet_count;
    logic [31:0] tcp_count;
    logic [31:0] icmp_count;
    logic [31:0] dns_count;
    logic [31:0] udp_count;
    logic [31:0] fin_count;
    logic [31:0] rst_count;
    logic [31:0] syn_count;
  } counters_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_port;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic        l4_present;
    logic        tcp_syn;
    logic        tcp_fin;
    logic        tcp_rst;
  } item_t;

  typedef struct packed {
    logic ld;       // capture input word
    logic set_hit;  // key found at current address
    logic clr_hit;  // key not in table
    logic next;     // advance scan address
    logic upd;      // apply update or read
    logic phase2;   // start port-entry lookup
    logic emit;     // load output register
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic match;
    logic last;
    logic is_read;
    logic need_l4;
    logic phase1;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// fct_ctrl
// Sequencer: scans the table for a key, then updates or reports.
// ----------------------------------------------------------------------------
module fct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fct_pkg::stat_t stat_i,
  output fct_pkg::cmd_t  cmd_o
);
  import fct_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StLook = 5'b00010,
    StCmp  = 5'b00100,
    StUpd  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          state_d  = StLook;
        end
      end
      StLook: begin
        if (stat_i.fill_zero) begin
          cmd_o.clr_hit = 1'b1;
          state_d       = StUpd;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        priority if (stat_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d       = StUpd;
        end else if (stat_i.last) begin
          cmd_o.clr_hit = 1'b1;
          state_d       = StUpd;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = StLook;
        end
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        if (!stat_i.is_read && !stat_i.phase1 && stat_i.need_l4) begin
          cmd_o.phase2 = 1'b1;
          state_d      = StLook;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/fct_dp.sv =====
// ----------------------------------------------------------------------------
// fct_dp
// Key and counter memories, fill count, scan address and output register.
// ----------------------------------------------------------------------------
module fct_dp #(
  parameter int unsigned TableEntries = fct_pkg::TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                command_i,
  input  fct_pkg::item_t      item_i,
  input  fct_pkg::cmd_t       cmd_i,
  output fct_pkg::stat_t      stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          out_status_o,
  output fct_pkg::counters_t  out_cnt_o
);
  import fct_pkg::*;

  localparam int unsigned AW = $clog2(TableEntries);
  localparam int unsigned FW = $clog2(TableEntries + 1);
  localparam logic [FW-1:0] FillMax = FW'(TableEntries);

  logic [63:0] key_mem [TableEntries];
  counters_t   cnt_mem [TableEntries];
  logic [63:0] key_rd_q;
  counters_t   cnt_rd_q;

  item_t       item_q;
  logic        read_q, phase_q, hit_q, shown_v_q, out_valid_q;
  logic [AW-1:0] addr_q;
  logic [FW-1:0] fill_q;
  status_e     status_q;
  counters_t   shown_q, out_cnt_q;
  logic [1:0]  out_status_q;

  logic [63:0] key;
  counters_t   base_row, new_row;
  logic        we;
  logic [AW-1:0] wa;
  logic        full;

  assign key = {phase_q ? item_q.l4_port : 16'h0000, item_q.src_ip[31:16], item_q.dst_ip};
  assign full = (fill_q == FillMax);

  // apply one update phase to a counter row
  always_comb begin
    base_row = hit_q ? cnt_rd_q : '0;
    new_row  = base_row;
    new_row.byte_count = base_row.byte_count + {16'h0000, item_q.total_length};
    if (!phase_q) begin
      new_row.packet_count = base_row.packet_count + 32'd1;
      if (item_q.protocol == ProtoIcmp) begin
        new_row.icmp_count = base_row.icmp_count + 32'd1;
      end
    end else if (item_q.protocol == ProtoUdp) begin
      new_row.udp_count = base_row.udp_count + 32'd1;
      if (item_q.l4_port == DnsPort) begin
        new_row.dns_count = base_row.dns_count + 32'd1;
      end
    end else begin
      new_row.tcp_count = base_row.tcp_count + 32'd1;
      priority if (item_q.tcp_syn) begin
        new_row.syn_count = base_row.syn_count + 32'd1;
      end else if (item_q.tcp_fin) begin
        new_row.fin_count = base_row.fin_count + 32'd1;
      end else if (item_q.tcp_rst) begin
        new_row.rst_count = base_row.rst_count + 32'd1;
      end
    end
  end

  assign we = cmd_i.upd && !read_q && (hit_q || !full);
  assign wa = hit_q ? addr_q : fill_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wa] <= key;
      cnt_mem[wa] <= new_row;
    end
    key_rd_q <= key_mem[addr_q];
    cnt_rd_q <= cnt_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      item_q <= item_i;
    end
    if (cmd_i.upd) begin
      if (read_q) begin
        shown_q <= cnt_rd_q;
      end else if (we) begin
        shown_q <= new_row;
      end
    end
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      out_cnt_q    <= shown_v_q ? shown_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q      <= 1'b0;
      phase_q     <= 1'b0;
      hit_q       <= 1'b0;
      shown_v_q   <= 1'b0;
      addr_q      <= '0;
      fill_q      <= '0;
      status_q    <= StatOk;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld) begin
        read_q    <= command_i;
        phase_q   <= command_i;
        addr_q    <= '0;
        shown_v_q <= 1'b0;
        status_q  <= StatOk;
      end
      if (cmd_i.next) begin
        addr_q <= addr_q + AW'(1);
      end
      if (cmd_i.set_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.clr_hit) begin
        hit_q <= 1'b0;
      end
      if (cmd_i.upd) begin
        if (read_q) begin
          shown_v_q <= hit_q;
          status_q  <= hit_q ? StatOk : StatAbsent;
        end else if (we) begin
          shown_v_q <= 1'b1;
          if (!hit_q) begin
            fill_q <= fill_q + FW'(1);
          end
        end else begin
          status_q <= StatFull;
        end
      end
      if (cmd_i.phase2) begin
        phase_q <= 1'b1;
        addr_q  <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.match     = (key_rd_q == key);
  assign stat_o.last      = (FW'(addr_q) + FW'(1) == fill_q);
  assign stat_o.is_read   = read_q;
  assign stat_o.need_l4   = item_q.l4_present &&
                            (item_q.protocol == ProtoUdp || item_q.protocol == ProtoTcp);
  assign stat_o.phase1    = phase_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_cnt_o    = out_cnt_q;

endmodule

// ===== sv/flow_counter_table.sv =====
// ----------------------------------------------------------------------------
// flow_counter_table
// Per-flow packet counter table with lookup, create and read.
// ----------------------------------------------------------------------------
// Input stream: one word per packet (tuser = 0, count) or per query
// (tuser = 1, read the entry for {l4_port, src_ip[31:16], dst_ip}).
// Output stream: one word per input word; tuser carries the status
// (0 ok, 1 table full, 2 key absent), tdata the nine counters of the entry
// last updated or read, or zeros if none.
// Entries fill from slot 0 up and are never freed, so a lookup scans slots
// 0..fill-1 linearly, each slot a registered memory read and then a compare.
// A count does one lookup, or two when a complete UDP/TCP header is present;
// a read does one.
// The input is ready only while the sequencer idles; a finished word waits in
// the output register and the next input word is taken meanwhile; the
// sequencer stalls before emitting if the receiver still holds the previous.
// Reset empties the table at once (fill count to zero); no clearing pass.
// ----------------------------------------------------------------------------
module flow_counter_table #(
  parameter int unsigned TableEntries = fct_pkg::TableEntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // src_ip, dst_ip, l4_port, protocol, total_length, l4_present,
  // tcp_syn, tcp_fin, tcp_rst, 4 zero pad bits
  input  logic [111:0] s_axis_tdata_i,
  // command
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // syn, rst, fin, udp, dns, icmp, tcp, packet, byte counts
  output logic [287:0] m_axis_tdata_o,
  // status
  output logic [1:0]   m_axis_tuser_o
);
  import fct_pkg::*;

  item_t     item;
  cmd_t      cmd;
  stat_t     stat;
  counters_t cnt;

  // unpack input word (lowest field first)
  assign item.src_ip       = s_axis_tdata_i[31:0];
  assign item.dst_ip       = s_axis_tdata_i[63:32];
  assign item.l4_port      = s_axis_tdata_i[79:64];
  assign item.protocol     = s_axis_tdata_i[87:80];
  assign item.total_length = s_axis_tdata_i[103:88];
  assign item.l4_present   = s_axis_tdata_i[104];
  assign item.tcp_syn      = s_axis_tdata_i[105];
  assign item.tcp_fin      = s_axis_tdata_i[106];
  assign item.tcp_rst      = s_axis_tdata_i[107];

  fct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fct_dp #(
    .TableEntries (TableEntries)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (s_axis_tuser_i),
    .item_i       (item),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (m_axis_tuser_o),
    .out_cnt_o    (cnt)
  );

  // counters_t is laid out with syn_count in the low bits
  assign m_axis_tdata_o = cnt;

endmodule

// ===== sv/fct_checker.sv =====
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks for the flow counter table.
// ----------------------------------------------------------------------------
module fct_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [287:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);
  import fct_pkg::*;

  // output word holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed under stall");

  // one word at a time: no accept right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == StatOk || m_axis_tuser_o == StatFull ||
                         m_axis_tuser_o == StatAbsent))
    else $error("bad status code");

  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == StatAbsent |-> m_axis_tdata_o == '0)
    else $error("absent key reported counters");

endmodule

bind flow_counter_table fct_checker u_fct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== bench/flow_counter_table_tb.sv =====
// ----------------------------------------------------------------------------
// flow_counter_table_tb
// Self-checking bench for the per-flow counter table.
// ----------------------------------------------------------------------------
// A class keeps its own copy of the flow table, predicts the status and
// counters for every accepted word, and checks each output word in order.
// Stimulus: a directed set (every protocol path, flag priority, port 0 and
// DNS port, field extremes, absent reads), then random traffic over a small
// pool of flows, then a fill run that takes the table to capacity, followed
// by words that hit the full table.
// ----------------------------------------------------------------------------
module flow_counter_table_tb;
  import fct_pkg::*;

  typedef struct {
    bit          is_read;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_port;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    bit          l4_present;
    bit          tcp_syn;
    bit          tcp_fin;
    bit          tcp_rst;
  } word_t;

  typedef struct {
    status_e   status;
    counters_t counts;
  } tally_t;

  // Mirror of the flow table; predicts and checks output words.
  class flow_table_model;
    int        slot_of [bit [63:0]];
    counters_t store[];
    int        fill;
    tally_t    pending_q[$];
    int        errors;
    string     field_name[9] = '{"syn", "rst", "fin", "udp", "dns", "icmp",
                                 "tcp", "packet", "byte"};

    function new();
      store  = new[TableEntriesDef];
      fill   = 0;
      errors = 0;
    endfunction

    // -1 when the key is missing and no slot is free
    function int find_or_make(bit [63:0] key);
      if (slot_of.exists(key)) return slot_of[key];
      if (fill >= TableEntriesDef) return -1;
      slot_of[key] = fill;
      store[fill]  = '0;
      fill++;
      return fill - 1;
    endfunction

    function void note_word(word_t w);
      bit [63:0] base_key, port_key;
      int        base, pe, shown;
      tally_t    t;
      base_key = {16'h0, w.src_ip[31:16], w.dst_ip};
      port_key = {w.l4_port, w.src_ip[31:16], w.dst_ip};
      t.status = StatOk;
      if (w.is_read) begin
        shown = slot_of.exists(port_key) ? slot_of[port_key] : -1;
        if (shown < 0) t.status = StatAbsent;
      end else begin
        base = find_or_make(base_key);
        if (base < 0) begin
          t.status = StatFull;
        end else begin
          store[base].packet_count += 1;
          store[base].byte_count   += w.total_length;
          if (w.protocol == ProtoIcmp) store[base].icmp_count += 1;
        end
        shown = base;
        if ((w.protocol == ProtoUdp || w.protocol == ProtoTcp) && w.l4_present) begin
          pe = find_or_make(port_key);
          if (pe < 0) begin
            t.status = StatFull;
          end else begin
            store[pe].byte_count += w.total_length;
            if (w.protocol == ProtoUdp) begin
              store[pe].udp_count += 1;
              if (w.l4_port == DnsPort) store[pe].dns_count += 1;
            end else begin
              store[pe].tcp_count += 1;
              // flag priority: SYN, then FIN, then RST
              if (w.tcp_syn) store[pe].syn_count += 1;
              else if (w.tcp_fin) store[pe].fin_count += 1;
              else if (w.tcp_rst) store[pe].rst_count += 1;
            end
            shown = pe;
          end
        end
      end
      t.counts = (shown < 0) ? '0 : store[shown];
      pending_q.push_back(t);
    endfunction

    function void check_word(logic [1:0] status, counters_t counts);
      tally_t t;
      if (pending_q.size() == 0) begin
        $display("%0t: output word with nothing pending, status %0d", $time, status);
        errors++;
        return;
      end
      t = pending_q.pop_front();
      if (status !== t.status) begin
        $display("%0t: status expected %0d actual %0d", $time, t.status, status);
        errors++;
      end
      for (int k = 0; k < 9; k++) begin
        if (counts[k*32 +: 32] !== t.counts[k*32 +: 32]) begin
          $display("%0t: %s count expected %0d actual %0d", $time, field_name[k],
                   t.counts[k*32 +: 32], counts[k*32 +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [111:0] s_data = '0;
  logic         s_user = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [287:0] m_data;
  logic [1:0]   m_user;

  flow_table_model flows = new();
  bit          long_hold_req = 1'b0;
  int          hold_cnt = 0;
  logic [15:0] src_hi_pool[4];
  logic [31:0] dst_pool[4];
  logic [15:0] port_pool[6];

  always #2 clk = ~clk;

  flow_counter_table i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: checks accepted words, stalls at random, and takes one long
  // hold on request so the block backs up into its input.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) flows.check_word(m_user, counters_t'(m_data));
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_ready  <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt <= 400;
      m_ready  <= 1'b0;
    end else begin
      hold_cnt <= pick_gap();
      m_ready  <= 1'b1;
    end
  end

  task automatic send_word(word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= w.is_read;
    // fields from bit 0 up, 4 pad bits on top
    s_data  <= {4'b0, w.tcp_rst, w.tcp_fin, w.tcp_syn, w.l4_present, w.total_length,
                w.protocol, w.l4_port, w.dst_ip, w.src_ip};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    flows.note_word(w);
  endtask

  function automatic word_t make_word(bit rd, logic [31:0] src, logic [31:0] dst,
                                      logic [15:0] port, logic [7:0] proto,
                                      logic [15:0] len, bit l4, bit syn, bit fin,
                                      bit rst);
    word_t w;
    w = '{rd, src, dst, port, proto, len, l4, syn, fin, rst};
    return w;
  endfunction

  // random traffic over a small set of flows, with the odd fresh key
  function automatic word_t rand_word();
    word_t w;
    int    r;
    w.is_read      = ($urandom_range(0, 99) < 20);
    w.src_ip       = {src_hi_pool[$urandom_range(0, 3)], 16'($urandom)};
    w.dst_ip       = dst_pool[$urandom_range(0, 3)];
    w.l4_port      = port_pool[$urandom_range(0, 5)];
    w.total_length = 16'($urandom);
    w.l4_present   = ($urandom_range(0, 99) < 85);
    w.tcp_syn      = 1'($urandom);
    w.tcp_fin      = 1'($urandom);
    w.tcp_rst      = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 35) w.protocol = ProtoTcp;
    else if (r < 65) w.protocol = ProtoUdp;
    else if (r < 80) w.protocol = ProtoIcmp;
    else w.protocol = 8'($urandom);
    if ($urandom_range(0, 99) < 3) begin
      w.src_ip  = $urandom;
      w.dst_ip  = $urandom;
      w.l4_port = 16'($urandom);
    end
    return w;
  endfunction

  initial begin
    word_t       w;
    logic [15:0] fill_port;
    foreach (src_hi_pool[i]) src_hi_pool[i] = 16'($urandom);
    foreach (dst_pool[i]) dst_pool[i] = $urandom;
    src_hi_pool[0] = 16'hFFFF;
    dst_pool[0]    = 32'hFFFF_FFFF;
    src_hi_pool[1] = 16'h0000;
    dst_pool[1]    = 32'h0000_0000;
    port_pool = '{16'd0, DnsPort, 16'd80, 16'hFFFF, 16'($urandom), 16'($urandom)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-table read, each protocol path, flag priority
    send_word(make_word(1, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, ProtoTcp, 0, 0, 0, 0, 0));
    send_word(make_word(0, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, ProtoTcp, 16'd60, 1, 1, 1, 1));
    send_word(make_word(0, 32'hC0A8_0002, 32'h0A00_0001, 16'd80, ProtoTcp, 16'd40, 1, 0, 1, 1));
    send_word(make_word(0, 32'hC0A8_0003, 32'h0A00_0001, 16'd80, ProtoTcp, 16'd40, 1, 0, 0, 1));
    send_word(make_word(0, 32'hC0A8_0004, 32'h0A00_0001, 16'd80, ProtoTcp, 16'd40, 1, 0, 0, 0));
    // TCP without a full L4 header: base entry only
    send_word(make_word(0, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, ProtoTcp, 16'd20, 0, 1, 0, 0));
    send_word(make_word(0, 32'h0102_0304, 32'h0808_0808, DnsPort, ProtoUdp, 16'd72, 1, 1, 1, 1));
    send_word(make_word(0, 32'h0102_0304, 32'h0808_0808, 16'd5353, ProtoUdp, 16'd90, 1, 0, 0, 0));
    send_word(make_word(0, 32'h0102_0304, 32'h0808_0808, 16'd0, ProtoIcmp, 16'd84, 1, 1, 1, 1));
    // port 0 on the L4 path: same entry updated twice
    send_word(make_word(0, 32'h0102_0304, 32'h0808_0808, 16'd0, ProtoUdp, 16'd33, 1, 0, 0, 0));
    send_word(make_word(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 1, 1, 1));
    send_word(make_word(0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 8'h00, 16'h0000, 0, 0, 0, 0));
    send_word(make_word(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, ProtoTcp, 16'hFFFF, 1, 1, 1, 1));
    // reads: port entries, base entries, absent key
    send_word(make_word(1, 32'hC0A8_FFFF, 32'h0A00_0001, 16'd80, 0, 0, 0, 0, 0, 0));
    send_word(make_word(1, 32'hC0A8_0000, 32'h0A00_0001, 16'd0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(1, 32'h0102_0000, 32'h0808_0808, DnsPort, 0, 0, 0, 0, 0, 0));
    send_word(make_word(1, 32'h0102_0000, 32'h0808_0808, 16'd0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(1, 32'hFFFF_0000, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 1, 1, 1));
    send_word(make_word(1, 32'h1234_5678, 32'h9ABC_DEF0, 16'd7, 0, 0, 0, 0, 0, 0));

    // random traffic; one long receiver hold and one drain pause
    for (int n = 0; n < 550; n++) begin
      if (n == 150) long_hold_req = 1'b1;
      if (n == 350) begin
        s_valid <= 1'b0;
        while (flows.pending_q.size() != 0) @(posedge clk);
      end
      send_word(rand_word());
    end

    // fill the table with port entries under one fresh base flow
    fill_port = 16'd1;
    while (flows.fill < TableEntriesDef) begin
      send_word(make_word(0, 32'h5A5A_0001, 32'h7F00_0001, fill_port, ProtoTcp,
                          16'd64, 1, 1, 0, 0));
      fill_port++;
    end
    // full table: new base key, new port under a known base, hits, reads
    send_word(make_word(0, 32'h6B6B_0001, 32'h7F00_0002, 16'd9, ProtoUdp, 16'd10, 1, 0, 0, 0));
    send_word(make_word(0, 32'h5A5A_0001, 32'h7F00_0001, 16'hFFF0, ProtoUdp, 16'd10, 1, 0, 0, 0));
    send_word(make_word(0, 32'h5A5A_0001, 32'h7F00_0001, 16'd1, ProtoTcp, 16'd10, 1, 0, 1, 0));
    send_word(make_word(1, 32'h5A5A_0001, 32'h7F00_0001, 16'd1, 0, 0, 0, 0, 0, 0));
    send_word(make_word(1, 32'h6B6B_0001, 32'h7F00_0002, 16'd9, 0, 0, 0, 0, 0, 0));
    for (int n = 0; n < 10; n++) send_word(rand_word());
    s_valid <= 1'b0;

    while (flows.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (flows.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit; the fill run and full-table scans dominate
  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
